>>> hdl/limit_order_book_matcher_core_macros.svh
// Assertion macros shared by the order book RTL.
// They assume a clock named clk and an active low reset named rst_n.
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define LOBM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// Order book matcher package
// Shared constants and codes of the limit order book matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

    localparam int ORDER_SLOTS_DEF = 64;
    localparam int PRICE_BITS_DEF  = 20;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register byte addresses.
    localparam logic [CFG_ADDR_W-1:0] REG_SYMBOL_ID = 3'd0;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_CANCEL = 1'b1;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_WRONG_SYM = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

>>> hdl/lobm_if.sv
// ----------------------------------------------------------------------------
// Order book channel interfaces
// Request channel into the book and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface lobm_req_if #(parameter int PRICE_BITS = lobm_pkg::PRICE_BITS_DEF) ();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [31:0]           order_id;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [31:0]           quantity;
    logic [15:0]           symbol;

    modport source (output valid, req_type, order_id, side, price, quantity, symbol,
                    input ready);
    modport sink (input valid, req_type, order_id, side, price, quantity, symbol,
                  output ready);
endinterface

interface lobm_res_if #(parameter int PRICE_BITS = lobm_pkg::PRICE_BITS_DEF) ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [1:0]            status;
    logic [31:0]           trade_qty;
    logic [PRICE_BITS-1:0] trade_price;
    logic [31:0]           buy_order_id;
    logic [31:0]           sell_order_id;
    logic [PRICE_BITS-1:0] best_bid;
    logic [PRICE_BITS-1:0] best_ask;
    logic [PRICE_BITS-1:0] spread;
    logic                  last;

    modport source (output valid, kind, status, trade_qty, trade_price, buy_order_id,
                    sell_order_id, best_bid, best_ask, spread, last,
                    input ready);
    modport sink (input valid, kind, status, trade_qty, trade_price, buy_order_id,
                  sell_order_id, best_bid, best_ask, spread, last,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/limit_order_book_matcher_core.sv
// ----------------------------------------------------------------------------
// Limit order book matcher core
// Single-instrument order book with price-time priority matching.
// ----------------------------------------------------------------------------
// Orders rest in a slot memory read one entry per cycle. Every request ends
// with a pass over all ORDER_SLOTS slots that finds the best bid, best ask
// and the oldest order at each. An add whose prices cross runs one such pass
// and two write-back states, buy then sell, per trade; a cancel adds one
// more pass to find the id. One request is worked on at a time, and each
// result waits in an output register until it is taken.
`default_nettype none
`include "limit_order_book_matcher_core_macros.svh"

module limit_order_book_matcher_core #(
    parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_BITS  = lobm_pkg::PRICE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lobm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [lobm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [lobm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready,
    lobm_req_if.sink                             req,
    lobm_res_if.source                           res
);

    localparam int AW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CW = $clog2(ORDER_SLOTS + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CANCEL = 6'b000010,
        S_SCAN   = 6'b000100,
        S_BUY    = 6'b001000,
        S_SELL   = 6'b010000,
        S_STATUS = 6'b100000
    } state_t;

    typedef struct packed {
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [31:0]           id;
        logic [15:0]           seq;
    } slot_t;

    slot_t       ord_mem [ORDER_SLOTS];
    logic [31:0] qty_mem [ORDER_SLOTS];

    state_t                 state_reg, state_next;
    logic [15:0]            symbol_id_reg;
    logic [ORDER_SLOTS-1:0] valid_reg;
    logic [15:0]            next_seq_reg;
    logic [31:0]            oid_reg;
    logic [1:0]             status_reg;
    logic                   match_reg;
    logic                   hit_reg;
    logic [CW-1:0]          scan_cnt_reg;
    logic                   pipe_vld_reg;
    logic [AW-1:0]          pipe_idx_reg;
    logic [CW-1:0]          trade_cnt_reg;
    slot_t                  ord_rd_reg;
    logic [31:0]            qty_rd_reg;

    logic                   bid_has_reg, ask_has_reg;
    logic [PRICE_BITS-1:0]  bid_px_reg, ask_px_reg;
    logic [15:0]            bid_age_reg, ask_age_reg;
    logic [AW-1:0]          bid_idx_reg, ask_idx_reg;
    logic [31:0]            bid_qty_reg, ask_qty_reg;
    logic [31:0]            bid_id_reg, ask_id_reg;

    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic [1:0]             out_status_reg;
    logic [31:0]            out_qty_reg;
    logic [PRICE_BITS-1:0]  out_price_reg;
    logic [31:0]            out_buy_id_reg, out_sell_id_reg;
    logic [PRICE_BITS-1:0]  out_bid_reg, out_ask_reg, out_spread_reg;
    logic                   out_last_reg;

    logic          req_fire;
    logic          out_free;
    logic          scanning;
    logic          scan_done;
    logic          free_found;
    logic [AW-1:0] free_idx;
    logic          add_ok;
    logic          ord_we;
    logic          qty_we;
    logic [AW-1:0] qty_waddr;
    logic [31:0]   qty_wdata;
    logic [31:0]   trade_m;
    logic [15:0]   entry_age;
    logic          entry_live;
    logic          crossed;
    logic          cfg_write;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == lobm_pkg::REG_SYMBOL_ID);

    always_comb
    begin
        prdata = '0;
        if (paddr == lobm_pkg::REG_SYMBOL_ID)
        begin
            prdata = {{(lobm_pkg::CFG_DATA_W - 16){1'b0}}, symbol_id_reg};
        end
    end

    // ------------------------------------------------------------------
    // Request decode and free slot search
    // ------------------------------------------------------------------
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || res.ready;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    assign add_ok = (req.req_type == lobm_pkg::REQ_ADD) && (req.symbol == symbol_id_reg)
                    && (req.quantity != 32'd0) && free_found;
    assign ord_we = req_fire && add_ok;

    // ------------------------------------------------------------------
    // Slot memories: one write port each, registered read
    // ------------------------------------------------------------------
    always_comb
    begin
        qty_we    = 1'b0;
        qty_waddr = free_idx;
        qty_wdata = req.quantity;
        if (ord_we)
        begin
            qty_we = 1'b1;
        end
        else if (state_reg == S_BUY && out_free)
        begin
            qty_we    = 1'b1;
            qty_waddr = bid_idx_reg;
            qty_wdata = bid_qty_reg - trade_m;
        end
        else if (state_reg == S_SELL)
        begin
            qty_we    = 1'b1;
            qty_waddr = ask_idx_reg;
            qty_wdata = ask_qty_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_rd_reg <= ord_mem[scan_cnt_reg[AW-1:0]];
        if (ord_we)
        begin
            ord_mem[free_idx] <= '{side: req.side, price: req.price,
                                   id: req.order_id, seq: next_seq_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        qty_rd_reg <= qty_mem[scan_cnt_reg[AW-1:0]];
        if (qty_we)
        begin
            qty_mem[qty_waddr] <= qty_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Scan pipeline and control
    // ------------------------------------------------------------------
    assign scanning   = (state_reg == S_CANCEL) || (state_reg == S_SCAN);
    assign scan_done  = (scan_cnt_reg == CW'(ORDER_SLOTS)) && !pipe_vld_reg;
    assign entry_live = pipe_vld_reg && valid_reg[pipe_idx_reg];
    assign entry_age  = next_seq_reg - ord_rd_reg.seq;
    assign crossed    = bid_has_reg && ask_has_reg && (bid_px_reg >= ask_px_reg);
    assign trade_m    = (bid_qty_reg < ask_qty_reg) ? bid_qty_reg : ask_qty_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.req_type == lobm_pkg::REQ_CANCEL) ? S_CANCEL : S_SCAN;
                end
            end
            S_CANCEL:
            begin
                if (scan_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (match_reg && crossed && (trade_cnt_reg != CW'(ORDER_SLOTS - 1)))
                    begin
                        state_next = S_BUY;
                    end
                    else
                    begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_BUY:
            begin
                if (out_free)
                begin
                    state_next = S_SELL;
                end
            end
            S_SELL:   state_next = S_SCAN;
            S_STATUS:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            symbol_id_reg <= '0;
            valid_reg     <= '0;
            next_seq_reg  <= '0;
            status_reg    <= lobm_pkg::ST_OK;
            match_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            scan_cnt_reg  <= '0;
            pipe_vld_reg  <= 1'b0;
            pipe_idx_reg  <= '0;
            trade_cnt_reg <= '0;
            bid_has_reg   <= 1'b0;
            ask_has_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                symbol_id_reg <= pwdata[15:0];
            end

            if (scanning && !scan_done)
            begin
                if (scan_cnt_reg != CW'(ORDER_SLOTS))
                begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
            end
            else
            begin
                scan_cnt_reg <= '0;
            end
            pipe_vld_reg <= scanning && !scan_done && (scan_cnt_reg != CW'(ORDER_SLOTS));
            pipe_idx_reg <= scan_cnt_reg[AW-1:0];

            // Each new pass starts with both sides empty.
            if (state_next == S_SCAN && state_reg != S_SCAN)
            begin
                bid_has_reg <= 1'b0;
                ask_has_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN && entry_live)
            begin
                if (ord_rd_reg.side == lobm_pkg::SIDE_BUY)
                begin
                    bid_has_reg <= 1'b1;
                end
                else
                begin
                    ask_has_reg <= 1'b1;
                end
            end

            if (state_reg == S_IDLE && req_fire)
            begin
                trade_cnt_reg <= '0;
                hit_reg       <= 1'b0;
                match_reg     <= add_ok;
                if (req.req_type == lobm_pkg::REQ_CANCEL)
                begin
                    status_reg <= lobm_pkg::ST_OK;
                end
                else if (req.symbol != symbol_id_reg)
                begin
                    status_reg <= lobm_pkg::ST_WRONG_SYM;
                end
                else if (req.quantity != 32'd0 && !free_found)
                begin
                    status_reg <= lobm_pkg::ST_FULL;
                end
                else
                begin
                    status_reg <= lobm_pkg::ST_OK;
                end
                if (add_ok)
                begin
                    valid_reg[free_idx] <= 1'b1;
                    next_seq_reg        <= next_seq_reg + 16'd1;
                end
            end

            if (state_reg == S_CANCEL)
            begin
                if (entry_live && ord_rd_reg.id == oid_reg)
                begin
                    valid_reg[pipe_idx_reg] <= 1'b0;
                    hit_reg                 <= 1'b1;
                end
                if (scan_done)
                begin
                    status_reg <= hit_reg ? lobm_pkg::ST_OK : lobm_pkg::ST_NOT_FOUND;
                end
            end

            if (state_reg == S_BUY && out_free)
            begin
                trade_cnt_reg <= trade_cnt_reg + CW'(1);
                if (bid_qty_reg == trade_m)
                begin
                    valid_reg[bid_idx_reg] <= 1'b0;
                end
            end

            if (state_reg == S_SELL && ask_qty_reg == 32'd0)
            begin
                valid_reg[ask_idx_reg] <= 1'b0;
            end

            if ((state_reg == S_BUY || state_reg == S_STATUS) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Best price and oldest order tracking, result payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            oid_reg <= req.order_id;
        end

        // A strictly better price restarts the age search; at an equal price
        // only a strictly older order wins, so ties keep the lower slot.
        if (state_reg == S_SCAN && entry_live)
        begin
            if (ord_rd_reg.side == lobm_pkg::SIDE_BUY)
            begin
                if (!bid_has_reg || ord_rd_reg.price > bid_px_reg
                    || (ord_rd_reg.price == bid_px_reg && entry_age > bid_age_reg))
                begin
                    bid_px_reg  <= ord_rd_reg.price;
                    bid_age_reg <= entry_age;
                    bid_idx_reg <= pipe_idx_reg;
                    bid_qty_reg <= qty_rd_reg;
                    bid_id_reg  <= ord_rd_reg.id;
                end
            end
            else
            begin
                if (!ask_has_reg || ord_rd_reg.price < ask_px_reg
                    || (ord_rd_reg.price == ask_px_reg && entry_age > ask_age_reg))
                begin
                    ask_px_reg  <= ord_rd_reg.price;
                    ask_age_reg <= entry_age;
                    ask_idx_reg <= pipe_idx_reg;
                    ask_qty_reg <= qty_rd_reg;
                    ask_id_reg  <= ord_rd_reg.id;
                end
            end
        end

        if (state_reg == S_BUY && out_free)
        begin
            ask_qty_reg     <= ask_qty_reg - trade_m;
            out_kind_reg    <= lobm_pkg::KIND_TRADE;
            out_status_reg  <= lobm_pkg::ST_OK;
            out_qty_reg     <= trade_m;
            out_price_reg   <= bid_px_reg;
            out_buy_id_reg  <= bid_id_reg;
            out_sell_id_reg <= ask_id_reg;
            out_bid_reg     <= '0;
            out_ask_reg     <= '0;
            out_spread_reg  <= '0;
            out_last_reg    <= 1'b0;
        end
        else if (state_reg == S_STATUS && out_free)
        begin
            out_kind_reg    <= lobm_pkg::KIND_STATUS;
            out_status_reg  <= status_reg;
            out_qty_reg     <= '0;
            out_price_reg   <= '0;
            out_buy_id_reg  <= '0;
            out_sell_id_reg <= '0;
            out_bid_reg     <= bid_has_reg ? bid_px_reg : '0;
            out_ask_reg     <= ask_has_reg ? ask_px_reg : '0;
            out_spread_reg  <= (bid_has_reg && ask_has_reg) ? (ask_px_reg - bid_px_reg) : '0;
            out_last_reg    <= 1'b1;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.kind          = out_kind_reg;
    assign res.status        = out_status_reg;
    assign res.trade_qty     = out_qty_reg;
    assign res.trade_price   = out_price_reg;
    assign res.buy_order_id  = out_buy_id_reg;
    assign res.sell_order_id = out_sell_id_reg;
    assign res.best_bid      = out_bid_reg;
    assign res.best_ask      = out_ask_reg;
    assign res.spread        = out_spread_reg;
    assign res.last          = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LOBM_ASSERT_ALWAYS(a_trade_bound, trade_cnt_reg <= CW'(ORDER_SLOTS - 1), "too many trades")
    `LOBM_ASSERT_ALWAYS(a_trade_crossed, (state_reg != S_BUY) || crossed, "trade without cross")
    `LOBM_ASSERT_NEXT(a_buy_then_sell, (state_reg == S_BUY) && out_free, state_reg == S_SELL, "sell write-back skipped")
    `LOBM_ASSERT_NEXT(a_status_last, (state_reg == S_STATUS) && out_free, (state_reg == S_IDLE) && out_valid_reg && out_last_reg, "status result lost")

endmodule

`default_nettype wire

>>> bench/limit_order_book_matcher_core_test.sv
// ----------------------------------------------------------------------------
// Limit order book matcher core testbench
// Drives add and cancel requests through the request channel and compares
// every trade and status result with an in-bench model of the book. A short
// stimulus table comes first. It is followed by a fill of the whole book,
// a sweep that hits the per-request trade bound, and random traffic under
// several symbol settings and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module limit_order_book_matcher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = lobm_pkg::ORDER_SLOTS_DEF;
    localparam int PB        = lobm_pkg::PRICE_BITS_DEF;
    localparam int PASS_WAIT = 2 * (SLOTS + 4) + 20;
    localparam int LIMIT     = 20000000;
    localparam logic [PB-1:0] PMAX = {PB{1'b1}};

    typedef struct {
        logic          req_type;
        logic [31:0]   order_id;
        logic          side;
        logic [PB-1:0] price;
        logic [31:0]   quantity;
        logic [15:0]   symbol;
    } order_req_t;

    typedef struct {
        logic          kind;
        logic [1:0]    status;
        logic [31:0]   trade_qty;
        logic [PB-1:0] trade_price;
        logic [31:0]   buy_order_id;
        logic [31:0]   sell_order_id;
        logic [PB-1:0] best_bid;
        logic [PB-1:0] best_ask;
        logic [PB-1:0] spread;
        logic          last;
    } book_result_t;

    typedef struct {
        order_req_t    r;
        bit            typed;
        logic [1:0]    status;
        logic [PB-1:0] bid;
        logic [PB-1:0] ask;
        logic [PB-1:0] spr;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [lobm_pkg::CFG_ADDR_W-1:0] paddr;
    logic [lobm_pkg::CFG_DATA_W-1:0] pwdata;
    logic [lobm_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    lobm_req_if #(.PRICE_BITS(PB)) req_ch ();
    lobm_res_if #(.PRICE_BITS(PB)) res_ch ();

    limit_order_book_matcher_core #(.ORDER_SLOTS(SLOTS), .PRICE_BITS(PB)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    // Book model state.
    logic          bk_valid [SLOTS];
    logic          bk_side  [SLOTS];
    logic [PB-1:0] bk_price [SLOTS];
    logic [31:0]   bk_qty   [SLOTS];
    logic [31:0]   bk_id    [SLOTS];
    logic [15:0]   bk_seq   [SLOTS];
    logic [15:0]   seq_ctr;
    logic [15:0]   book_symbol;

    book_result_t pending_results[$];
    int  stall_pct;
    int  idle_pct;
    int  cycles;
    bit  failed;
    int  n_requests;
    int  n_trades;
    int  n_status;
    int  n_full;
    int  n_not_found;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("limit_order_book_matcher_core_test: FAIL");
            $finish;
        end
    end

    function automatic bit best_on_side(input logic s, output logic [PB-1:0] p);
        bit found;
        found = 1'b0;
        p = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (bk_valid[i] && bk_side[i] == s)
            begin
                if (!found || (s == lobm_pkg::SIDE_BUY ? bk_price[i] > p : bk_price[i] < p))
                begin
                    p = bk_price[i];
                    found = 1'b1;
                end
            end
        end
        return found;
    endfunction

    function automatic int oldest_order(input logic s, input logic [PB-1:0] p);
        int pick;
        logic [15:0] age;
        logic [15:0] best_age;
        pick = -1;
        best_age = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (bk_valid[i] && bk_side[i] == s && bk_price[i] == p)
            begin
                age = seq_ctr - bk_seq[i];
                if (pick < 0 || age > best_age)
                begin
                    pick = i;
                    best_age = age;
                end
            end
        end
        return pick;
    endfunction

    // Applies one request to the book model and returns the results it causes.
    task automatic apply_request(input order_req_t r, output book_result_t q[$]);
        book_result_t e;
        logic [1:0]    st;
        logic [PB-1:0] bb;
        logic [PB-1:0] ba;
        logic [31:0]   m;
        bit hb;
        bit ha;
        bit hit;
        int slot;
        int bi;
        int ai;
        q = {};
        st = lobm_pkg::ST_OK;
        if (r.req_type == lobm_pkg::REQ_ADD)
        begin
            if (r.symbol != book_symbol)
                st = lobm_pkg::ST_WRONG_SYM;
            else if (r.quantity != 0)
            begin
                slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot < 0 && !bk_valid[i])
                        slot = i;
                if (slot < 0)
                    st = lobm_pkg::ST_FULL;
                else
                begin
                    bk_valid[slot] = 1'b1;
                    bk_side[slot]  = r.side;
                    bk_price[slot] = r.price;
                    bk_qty[slot]   = r.quantity;
                    bk_id[slot]    = r.order_id;
                    bk_seq[slot]   = seq_ctr;
                    seq_ctr        = seq_ctr + 16'd1;
                    while (q.size() < SLOTS - 1)
                    begin
                        if (!best_on_side(lobm_pkg::SIDE_BUY, bb)
                            || !best_on_side(lobm_pkg::SIDE_SELL, ba) || bb < ba)
                            break;
                        bi = oldest_order(lobm_pkg::SIDE_BUY, bb);
                        ai = oldest_order(lobm_pkg::SIDE_SELL, ba);
                        m = bk_qty[bi] < bk_qty[ai] ? bk_qty[bi] : bk_qty[ai];
                        bk_qty[bi] -= m;
                        bk_qty[ai] -= m;
                        e = '{lobm_pkg::KIND_TRADE, lobm_pkg::ST_OK, m, bb, bk_id[bi],
                              bk_id[ai], '0, '0, '0, 1'b0};
                        q.push_back(e);
                        if (bk_qty[bi] == 0)
                            bk_valid[bi] = 1'b0;
                        if (bk_qty[ai] == 0)
                            bk_valid[ai] = 1'b0;
                    end
                end
            end
        end
        else
        begin
            hit = 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (bk_valid[i] && bk_id[i] == r.order_id)
                begin
                    bk_valid[i] = 1'b0;
                    hit = 1'b1;
                end
            end
            if (!hit)
                st = lobm_pkg::ST_NOT_FOUND;
        end
        hb = best_on_side(lobm_pkg::SIDE_BUY, bb);
        ha = best_on_side(lobm_pkg::SIDE_SELL, ba);
        e = '{lobm_pkg::KIND_STATUS, st, '0, '0, '0, '0, hb ? bb : '0, ha ? ba : '0,
              (hb && ha) ? ba - bb : '0, 1'b1};
        q.push_back(e);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // Result side: random stalls, compare each taken result with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        book_result_t e;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    e = pending_results[0];
                    pending_results.delete(0);
                    check_field("kind", e.kind, res_ch.kind);
                    check_field("status", e.status, res_ch.status);
                    check_field("trade_qty", e.trade_qty, res_ch.trade_qty);
                    check_field("trade_price", e.trade_price, res_ch.trade_price);
                    check_field("buy_order_id", e.buy_order_id, res_ch.buy_order_id);
                    check_field("sell_order_id", e.sell_order_id, res_ch.sell_order_id);
                    check_field("best_bid", e.best_bid, res_ch.best_bid);
                    check_field("best_ask", e.best_ask, res_ch.best_ask);
                    check_field("spread", e.spread, res_ch.spread);
                    check_field("last", e.last, res_ch.last);
                    if (e.kind == lobm_pkg::KIND_TRADE)
                        n_trades++;
                    else
                    begin
                        n_status++;
                        if (e.status == lobm_pkg::ST_FULL)
                            n_full++;
                        if (e.status == lobm_pkg::ST_NOT_FOUND)
                            n_not_found++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Must be entered right after a rising edge; leaves right after the accepting edge.
    task automatic send_request(input order_req_t r, input bit typed = 1'b0,
                                input logic [1:0] st = lobm_pkg::ST_OK,
                                input logic [PB-1:0] bid = '0,
                                input logic [PB-1:0] ask = '0, input logic [PB-1:0] spr = '0);
        book_result_t q[$];
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.req_type;
        req_ch.order_id <= r.order_id;
        req_ch.side     <= r.side;
        req_ch.price    <= r.price;
        req_ch.quantity <= r.quantity;
        req_ch.symbol   <= r.symbol;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_request(r, q);
        if (typed)
        begin
            q[q.size()-1].status   = st;
            q[q.size()-1].best_bid = bid;
            q[q.size()-1].best_ask = ask;
            q[q.size()-1].spread   = spr;
        end
        foreach (q[i])
            pending_results.push_back(q[i]);
        n_requests++;
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PASS_WAIT) @(posedge clk);
    endtask

    task automatic write_symbol(input logic [15:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lobm_pkg::REG_SYMBOL_ID;
        pwdata  <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book_symbol = value;
        @(posedge clk);
    endtask

    function automatic order_req_t mk(input logic t, input logic [31:0] id, input logic s,
                                      input logic [PB-1:0] p, input logic [31:0] qty,
                                      input logic [15:0] sym);
        order_req_t r;
        r = '{t, id, s, p, qty, sym};
        return r;
    endfunction

    // Cancels every order still resting so the next part starts from an empty book.
    task automatic clear_book();
        logic [31:0] id;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (bk_valid[i])
            begin
                id = bk_id[i];
                send_request(mk(lobm_pkg::REQ_CANCEL, id, lobm_pkg::SIDE_BUY, '0, '0, '0));
            end
        end
    endtask

    function automatic order_req_t random_request(input logic [PB-1:0] mid);
        order_req_t r;
        int pick;
        int cnt;
        r.req_type = lobm_pkg::REQ_ADD;
        r.order_id = ($urandom_range(99) < 50) ? $urandom_range(0, 31) : $urandom;
        r.side     = $urandom_range(0, 1);
        r.price    = ($urandom_range(99) < 8) ? PB'($urandom)
                                              : mid + PB'($urandom_range(0, 20)) - PB'(10);
        r.quantity = ($urandom_range(99) < 10) ? $urandom : $urandom_range(0, 9);
        r.symbol   = ($urandom_range(99) < 6) ? 16'($urandom) : book_symbol;
        if ($urandom_range(99) < 22)
        begin
            r.req_type = lobm_pkg::REQ_CANCEL;
            r.symbol = 16'($urandom);
            if ($urandom_range(99) < 80)
            begin
                cnt = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (bk_valid[i])
                        cnt++;
                if (cnt > 0)
                begin
                    pick = $urandom_range(0, cnt - 1);
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (bk_valid[i])
                        begin
                            if (pick == 0)
                                r.order_id = bk_id[i];
                            pick--;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        logic [PB-1:0] mids[4];
        logic [15:0]   syms[4];
        int idles[4];
        int stalls[4];

        rst_n = 1'b0;
        cycles = 0;
        failed = 1'b0;
        n_requests = 0;
        n_trades = 0;
        n_status = 0;
        n_full = 0;
        n_not_found = 0;
        stall_pct = 0;
        idle_pct = 0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= lobm_pkg::REQ_ADD;
        req_ch.order_id <= '0;
        req_ch.side     <= lobm_pkg::SIDE_BUY;
        req_ch.price    <= '0;
        req_ch.quantity <= '0;
        req_ch.symbol   <= '0;
        for (int i = 0; i < SLOTS; i++)
            bk_valid[i] = 1'b0;
        seq_ctr = '0;
        book_symbol = '0;

        // Directed table; the status, bid, ask and spread of rows with typed set are written out by hand.
        row = '{mk(lobm_pkg::REQ_CANCEL, 5, lobm_pkg::SIDE_BUY, 0, 0, 0), 1'b1,
                lobm_pkg::ST_NOT_FOUND, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 1, lobm_pkg::SIDE_BUY, 100, 5, 1), 1'b1,
                lobm_pkg::ST_WRONG_SYM, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 1, lobm_pkg::SIDE_BUY, 100, 0, 0), 1'b1,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 1, lobm_pkg::SIDE_BUY, 0, 5, 0), 1'b1,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 2, lobm_pkg::SIDE_SELL, PMAX, 3, 0), 1'b1,
                lobm_pkg::ST_OK, 0, PMAX, PMAX};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 3, lobm_pkg::SIDE_BUY, PMAX, 32'hFFFF_FFFF, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 4, lobm_pkg::SIDE_SELL, 1, 10, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_CANCEL, 3, lobm_pkg::SIDE_SELL, 0, 0, 16'hFFFF), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 7, lobm_pkg::SIDE_BUY, 50, 2, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 7, lobm_pkg::SIDE_BUY, 40, 2, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_CANCEL, 7, lobm_pkg::SIDE_BUY, 0, 0, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 32'hFFFF_FFFF, lobm_pkg::SIDE_SELL, 60, 1, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 0, lobm_pkg::SIDE_BUY, 60, 1, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 8, lobm_pkg::SIDE_BUY, 70, 1, 16'hFFFF), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_CANCEL, 1, lobm_pkg::SIDE_BUY, 0, 0, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_CANCEL, 4, lobm_pkg::SIDE_BUY, 0, 0, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 20, lobm_pkg::SIDE_SELL, 30, 1, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 21, lobm_pkg::SIDE_SELL, 30, 1, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);
        row = '{mk(lobm_pkg::REQ_ADD, 22, lobm_pkg::SIDE_BUY, 35, 2, 0), 1'b0,
                lobm_pkg::ST_OK, 0, 0, 0};
        rows.push_back(row);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_request(rows[i].r, rows[i].typed, rows[i].status, rows[i].bid,
                         rows[i].ask, rows[i].spr);
        clear_book();

        // Fill every slot, overflow once, then one sell sweeps up to the trade bound.
        for (int i = 0; i < SLOTS; i++)
            send_request(mk(lobm_pkg::REQ_ADD, 1000 + i, lobm_pkg::SIDE_BUY, 10, 1, 0));
        send_request(mk(lobm_pkg::REQ_ADD, 2000, lobm_pkg::SIDE_SELL, 10, 1, 0));
        send_request(mk(lobm_pkg::REQ_CANCEL, 1000, lobm_pkg::SIDE_BUY, 0, 0, 0));
        send_request(mk(lobm_pkg::REQ_ADD, 2001, lobm_pkg::SIDE_SELL, 5, 100, 0));
        clear_book();

        mids   = '{PB'(1000), PB'(16), PMAX - PB'(15), PB'(500000)};
        syms   = '{16'hFFFF, 16'h0000, 16'h5AA5, 16'h0000};
        idles  = '{0, 71, 0, 31};
        stalls = '{0, 0, 71, 31};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_symbol(ph == 2 ? 16'($urandom) : syms[ph]);
            idle_pct = idles[ph];
            stall_pct = stalls[ph];
            for (int n = 0; n < 80; n++)
                send_request(random_request(mids[ph]));
        end

        idle_pct = 0;
        stall_pct = 0;
        wait_idle();
        $display("Ran %0d requests: %0d trades, %0d status results (%0d book full, %0d id misses).",
                 n_requests, n_trades, n_status, n_full, n_not_found);
        $display("Covered four symbol settings and four sender/receiver idling mixes.");
        if (!failed)
            $display("limit_order_book_matcher_core_test: PASS");
        else
            $display("limit_order_book_matcher_core_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
